// ===== rtl/core/hpt_pkg.sv =====
package hpt_pkg;

  localparam int BUCKETS_DEF = 64;
  localparam int WAYS_DEF    = 4;

  localparam int KIND_W = 2;
  localparam int PAGE_W = 20;
  localparam int BIDX_W = 6;
  localparam int CNT_W  = 32;
  localparam int DROP_W = 5;

  localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // bucket hash: ((HASH_MUL * page + HASH_ADD) mod HASH_MOD) mod BUCKETS
  localparam int HASH_X_W  = 36;
  localparam int HASH_HI_W = 16;
  localparam int HASH_SH   = 20;
  localparam int HASH_M_W  = 21;
  localparam int HASH_R0_W = 23;
  localparam logic [15:0]         HASH_MUL = 16'd35759;
  localparam logic [HASH_X_W-1:0] HASH_ADD = 36'd128932;
  localparam logic [HASH_M_W-1:0] HASH_MOD = 21'd1302397;
  localparam logic [19:0] HASH_RECIP = 20'(64'd1099511627776 / 64'(HASH_MOD));

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic              owner;
    logic [PAGE_W-1:0] page;
  } slot_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] page_number;
    logic              owner;
    logic              is_write;
    logic [BIDX_W-1:0] bucket_index;
  } in_word_t;

  typedef struct packed {
    logic             hit;
    logic             full_res;
    logic [CNT_W-1:0] disk_reads;
    logic [CNT_W-1:0] disk_writes;
    logic [CNT_W-1:0] inserts_owner0;
    logic [CNT_W-1:0] inserts_owner1;
    logic [CNT_W-1:0] inserts_total;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic hash_start;
    logic rd_en;
    logic upd_en;
    logic out_load;
    logic clr_en;
  } cmd_t;

  typedef struct packed {
    logic in_access;
    logic in_row;
    logic hash_done;
    logic clr_last;
    logic out_free;
  } stat_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [DROP_W-1:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, v} + (CNT_W+1)'(n);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/hpt_ram.sv =====
module hpt_ram #(
  parameter int WIDTH = hpt_pkg::WAYS_DEF * $bits(hpt_pkg::slot_t),
  parameter int DEPTH = hpt_pkg::BUCKETS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/hpt_hash.sv =====
module hpt_hash #(
  parameter int BUCKETS = hpt_pkg::BUCKETS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hpt_pkg::PAGE_W-1:0]  page,
  output logic                        done,
  output logic [$clog2(BUCKETS)-1:0]  bucket
);

  localparam int BW     = $clog2(BUCKETS);
  localparam int STAGES = 7;
  localparam int MW     = hpt_pkg::HASH_M_W;
  localparam int XW     = hpt_pkg::HASH_X_W;
  localparam logic [MW:0] BKT_RECIP = (MW+1)'((64'd1 << MW) / 64'(BUCKETS));
  localparam logic [12:0] BKT_K     = 13'(BUCKETS);

  logic [STAGES-1:0]           v_r;
  logic [XW-1:0]               x_r, x2_r, x_nxt;
  logic [XW-1:0]               p_r, p_nxt;
  logic [hpt_pkg::HASH_R0_W-1:0] r0_r, r0_nxt;
  logic [MW-1:0]               r_r, r5_r, r_nxt;
  logic [2*MW:0]               pb_r, pb_nxt;
  logic [BW:0]                 rb0_r, rb0_nxt;
  logic [BW-1:0]               bkt_r, bkt_nxt;
  logic [XW:0]                 qc;
  logic [MW+12:0]              qbk;
  logic [hpt_pkg::HASH_R0_W-1:0] d1, d2;

  always_comb begin
    x_nxt  = XW'(page) * XW'(hpt_pkg::HASH_MUL) + hpt_pkg::HASH_ADD;
    p_nxt  = XW'(x_r[XW-1 -: hpt_pkg::HASH_HI_W]) * XW'(hpt_pkg::HASH_RECIP);
    qc     = (XW+1)'(p_r[XW-1 -: hpt_pkg::HASH_HI_W]) * (XW+1)'(hpt_pkg::HASH_MOD);
    r0_nxt = hpt_pkg::HASH_R0_W'(({1'b0, x2_r} - qc));
    // quotient estimate is low by at most two
    d1     = r0_r - hpt_pkg::HASH_R0_W'(hpt_pkg::HASH_MOD);
    d2     = r0_r - hpt_pkg::HASH_R0_W'({hpt_pkg::HASH_MOD, 1'b0});
    if (r0_r >= hpt_pkg::HASH_R0_W'({hpt_pkg::HASH_MOD, 1'b0})) begin
      r_nxt = MW'(d2);
    end else if (r0_r >= hpt_pkg::HASH_R0_W'(hpt_pkg::HASH_MOD)) begin
      r_nxt = MW'(d1);
    end else begin
      r_nxt = MW'(r0_r);
    end
    pb_nxt  = (2*MW+1)'(r_r) * (2*MW+1)'(BKT_RECIP);
    qbk     = (MW+13)'(pb_r[2*MW -: (MW+1)]) * (MW+13)'(BKT_K);
    rb0_nxt = (BW+1)'((MW+13)'(r5_r) - qbk);
    bkt_nxt = (rb0_r >= (BW+1)'(BUCKETS)) ? BW'(rb0_r - (BW+1)'(BUCKETS)) : BW'(rb0_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[STAGES-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_nxt;
    end
    p_r   <= p_nxt;
    x2_r  <= x_r;
    r0_r  <= r0_nxt;
    r_r   <= r_nxt;
    pb_r  <= pb_nxt;
    r5_r  <= r_r;
    rb0_r <= rb0_nxt;
    bkt_r <= bkt_nxt;
  end

  assign done   = v_r[STAGES-1];
  assign bucket = bkt_r;

endmodule

// ===== rtl/core/hpt_dp.sv =====
module hpt_dp #(
  parameter int BUCKETS = hpt_pkg::BUCKETS_DEF,
  parameter int WAYS    = hpt_pkg::WAYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hpt_pkg::in_word_t   in_data,
  input  hpt_pkg::cmd_t       cmd,
  output hpt_pkg::stat_t      st,
  output logic                out_valid,
  input  logic                out_ready,
  output hpt_pkg::out_word_t  out_data
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int ROW_W = WAYS * $bits(hpt_pkg::slot_t);
  localparam int CW    = hpt_pkg::CNT_W;
  localparam int DW    = hpt_pkg::DROP_W;

  hpt_pkg::in_word_t  in_r;
  hpt_pkg::out_word_t out_r;
  logic               out_valid_r;
  logic [BW-1:0]      addr_r, clr_cnt_r;
  logic               hit_r, full_r;
  logic [CW-1:0]      reads_r, writes_r, own0_r, own1_r, total_r;
  logic [CW-1:0]      reads_nxt, writes_nxt, own0_nxt, own1_nxt, total_nxt;

  logic               hash_done;
  logic [BW-1:0]      hash_bkt;
  logic [ROW_W-1:0]   ram_rdata, ram_wdata;
  logic [BW-1:0]      ram_waddr;

  hpt_pkg::slot_t [WAYS-1:0] row_rd, row_nxt;
  logic [WAYS-1:0]    match_v, dd_v;
  logic               hit_c, full_c, miss_c, ins_c, found;

  hpt_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.hash_start),
    .page   (in_data.page_number),
    .done   (hash_done),
    .bucket (hash_bkt)
  );

  assign ram_waddr = cmd.clr_en ? clr_cnt_r : addr_r;
  assign ram_wdata = cmd.clr_en ? '0 : ROW_W'(row_nxt);

  hpt_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_ram (
    .clk   (clk),
    .we    (cmd.upd_en | cmd.clr_en),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign row_rd = ram_rdata;

  always_comb begin
    row_nxt = row_rd;
    hit_c   = 1'b0;
    full_c  = 1'b0;
    miss_c  = 1'b0;
    found   = 1'b0;
    dd_v    = '0;
    for (int w = 0; w < WAYS; w++) begin
      match_v[w] = row_rd[w].valid && (row_rd[w].page == in_r.page_number) &&
                   (row_rd[w].owner == in_r.owner);
    end
    if (in_r.kind == hpt_pkg::KIND_ACCESS) begin
      hit_c = |match_v;
      if (hit_c) begin
        for (int w = 0; w < WAYS; w++) begin
          if (match_v[w] && in_r.is_write) begin
            row_nxt[w].dirty = 1'b1;
          end
        end
      end else begin
        miss_c = 1'b1;
        for (int w = 0; w < WAYS; w++) begin
          if (!row_rd[w].valid && !found) begin
            found      = 1'b1;
            row_nxt[w] = '{valid: 1'b1, dirty: in_r.is_write, owner: in_r.owner,
                           page: in_r.page_number};
          end
        end
        full_c = !found;
      end
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (row_rd[w].valid &&
            (in_r.kind == hpt_pkg::KIND_CLEAR || row_rd[w].owner == in_r.owner)) begin
          dd_v[w]    = row_rd[w].dirty;
          row_nxt[w] = '0;
        end
      end
    end
    ins_c      = miss_c && found;
    reads_nxt  = hpt_pkg::sat_add(reads_r, DW'(miss_c));
    writes_nxt = hpt_pkg::sat_add(writes_r, DW'($countones(dd_v)));
    own0_nxt   = hpt_pkg::sat_add(own0_r, DW'(ins_c && !in_r.owner));
    own1_nxt   = hpt_pkg::sat_add(own1_r, DW'(ins_c && in_r.owner));
    total_nxt  = hpt_pkg::sat_add(total_r, DW'(ins_c));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      reads_r     <= '0;
      writes_r    <= '0;
      own0_r      <= '0;
      own1_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + BW'(1);
      end
      if (cmd.upd_en) begin
        reads_r  <= reads_nxt;
        writes_r <= writes_nxt;
        own0_r   <= own0_nxt;
        own1_r   <= own1_nxt;
        total_r  <= total_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r   <= in_data;
      addr_r <= BW'(in_data.bucket_index);
      hit_r  <= 1'b0;
      full_r <= 1'b0;
    end else if (hash_done) begin
      addr_r <= hash_bkt;
    end else if (cmd.upd_en) begin
      hit_r  <= hit_c;
      full_r <= full_c;
    end
    if (cmd.out_load) begin
      out_r <= '{hit: hit_r, full_res: full_r, disk_reads: reads_r, disk_writes: writes_r,
                 inserts_owner0: own0_r, inserts_owner1: own1_r, inserts_total: total_r};
    end
  end

  assign st.in_access = (in_data.kind == hpt_pkg::KIND_ACCESS);
  assign st.in_row    = (in_data.kind == hpt_pkg::KIND_FLUSH ||
                         in_data.kind == hpt_pkg::KIND_CLEAR) &&
                        (32'(in_data.bucket_index) < 32'(BUCKETS));
  assign st.hash_done = hash_done;
  assign st.clr_last  = (clr_cnt_r == BW'(BUCKETS - 1));
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/hpt_ctrl.sv =====
module hpt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hpt_pkg::stat_t  st,
  output hpt_pkg::cmd_t   cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_HASH   = 6'b000100,
    ST_READ   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_POST   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          priority if (st.in_access) begin
            cmd.hash_start = 1'b1;
            state_nxt      = ST_HASH;
          end else if (st.in_row) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_POST;
          end
        end
      end
      ST_HASH: begin
        if (st.hash_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.upd_en = 1'b1;
        state_nxt  = ST_POST;
      end
      ST_POST: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

// ===== rtl/core/hashed_page_table_unit.sv =====
// Access word: hash pipeline, bucket read, update, result load; the next word can be
// taken the cycle after the result is loaded. Flush/clear word: bucket read, update,
// result load. Unused kind or bucket out of range: result load only.
// One word in flight at a time; in_ready is high only in the idle state.
// Reset (rst_n low, synchronous) zeroes counters, then a clearing pass writes
// every bucket row before in_ready first rises.
module hashed_page_table_unit #(
  parameter int BUCKETS = hpt_pkg::BUCKETS_DEF,
  parameter int WAYS    = hpt_pkg::WAYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hpt_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hpt_pkg::out_word_t out_data
);

  hpt_pkg::cmd_t  cmd;
  hpt_pkg::stat_t st;

  hpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hpt_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while previous word in flight");

  a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.full_res))
    else $error("hit and full reported together");

  a_total_ge_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.inserts_total >= out_data.inserts_owner0) &&
                  (out_data.inserts_total >= out_data.inserts_owner1))
    else $error("insert totals inconsistent");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int          NBKT     = 64;
  localparam int          NWAY     = 4;
  localparam int          N_RAND   = 2000;
  localparam int          LIMIT    = 500000;
  localparam int          HOLD_LEN = 400;
  localparam logic [1:0]  KIND_NOP = 2'd3;
  localparam int          GROUPS   = 8;
  localparam int          PER_GRP  = 6;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  hpt_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hpt_pkg::out_word_t out_data;

  hpt_pkg::in_word_t  stim_q[$];
  hpt_pkg::out_word_t resp_q[$];
  logic      in_took = 1'b0;
  int        acc_cnt = 0;
  int        n_items = 1;
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;

  // page table shadow
  logic        pt_valid[NBKT*NWAY];
  logic        pt_dirty[NBKT*NWAY];
  logic        pt_owner[NBKT*NWAY];
  logic [19:0] pt_page[NBKT*NWAY];
  logic [31:0] n_reads = '0;
  logic [31:0] n_writes = '0;
  logic [31:0] n_ins0 = '0;
  logic [31:0] n_ins1 = '0;
  logic [31:0] n_ins_all = '0;

  logic [19:0] hot_pages[GROUPS*PER_GRP];
  logic [5:0]  hot_bkt[GROUPS];

  hashed_page_table_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned bucket_of(logic [19:0] pg);
    longint unsigned h;
    h = (64'd35759 * 64'(pg) + 64'd128932) % 64'd1302397;
    return int'(h % NBKT);
  endfunction

  function automatic logic [19:0] next_in_bucket(logic [19:0] from, int unsigned b);
    logic [19:0] p;
    p = from + 20'd1;
    while (bucket_of(p) != b) p = p + 20'd1;
    return p;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void drop_bucket(logic [5:0] b, logic any_owner, logic who);
    int s;
    if (b >= NBKT) return;
    for (int w = 0; w < NWAY; w++) begin
      s = b * NWAY + w;
      if (pt_valid[s] && (any_owner || pt_owner[s] == who)) begin
        if (pt_dirty[s]) n_writes = sat_inc(n_writes);
        pt_valid[s] = 1'b0;
        pt_dirty[s] = 1'b0;
        pt_owner[s] = 1'b0;
        pt_page[s]  = '0;
      end
    end
  endfunction

  function automatic hpt_pkg::out_word_t table_step(hpt_pkg::in_word_t w);
    hpt_pkg::out_word_t r;
    int b, s, free_s;
    logic hit, full;
    hit = 1'b0;
    full = 1'b0;
    free_s = -1;
    if (w.kind == hpt_pkg::KIND_ACCESS) begin
      b = bucket_of(w.page_number);
      for (int k = 0; k < NWAY; k++) begin
        s = b * NWAY + k;
        if (!hit) begin
          if (pt_valid[s]) begin
            if (pt_page[s] == w.page_number && pt_owner[s] == w.owner) begin
              hit = 1'b1;
              if (w.is_write) pt_dirty[s] = 1'b1;
            end
          end else if (free_s < 0) begin
            free_s = s;
          end
        end
      end
      if (!hit) begin
        n_reads = sat_inc(n_reads);
        if (free_s < 0) begin
          full = 1'b1;
        end else begin
          pt_valid[free_s] = 1'b1;
          pt_dirty[free_s] = w.is_write;
          pt_owner[free_s] = w.owner;
          pt_page[free_s]  = w.page_number;
          if (w.owner) n_ins1 = sat_inc(n_ins1);
          else n_ins0 = sat_inc(n_ins0);
          n_ins_all = sat_inc(n_ins_all);
        end
      end
    end else if (w.kind == hpt_pkg::KIND_FLUSH) begin
      drop_bucket(w.bucket_index, 1'b0, w.owner);
    end else if (w.kind == hpt_pkg::KIND_CLEAR) begin
      drop_bucket(w.bucket_index, 1'b1, 1'b0);
    end
    r.hit            = hit;
    r.full_res       = full;
    r.disk_reads     = n_reads;
    r.disk_writes    = n_writes;
    r.inserts_owner0 = n_ins0;
    r.inserts_owner1 = n_ins1;
    r.inserts_total  = n_ins_all;
    return r;
  endfunction

  task automatic add_word(logic [1:0] kind, logic [19:0] pg, logic who, logic wr,
                          logic [5:0] bidx);
    hpt_pkg::in_word_t w;
    w.kind         = kind;
    w.page_number  = pg;
    w.owner        = who;
    w.is_write     = wr;
    w.bucket_index = bidx;
    stim_q.push_back(w);
  endtask

  // driver
  always @(negedge clk) begin
    int ph, pct;
    if (rst_n && (!in_valid || in_took)) begin
      ph  = acc_cnt * 3 / n_items;
      pct = (ph == 0) ? 7 : (ph == 1) ? 83 : 0;
      if (stim_q.size() != 0 && $urandom_range(99) >= pct) begin
        in_data  <= stim_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    int ph, pct;
    ph  = acc_cnt * 3 / n_items;
    pct = (ph == 0) ? 83 : (ph == 1) ? 7 : 0;
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= pct);
  end

  // long receiver hold-off to back up the input
  always @(posedge clk) begin
    if (!hold_done && acc_cnt >= (n_items * 5) / 6) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    hpt_pkg::out_word_t e;
    if (rst_n) begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        resp_q.push_back(table_step(in_data));
        acc_cnt <= acc_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (resp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected word: %p", out_data);
        end else begin
          e = resp_q.pop_front();
          if (out_data.hit !== e.hit || out_data.full_res !== e.full_res ||
              out_data.disk_reads !== e.disk_reads ||
              out_data.disk_writes !== e.disk_writes ||
              out_data.inserts_owner0 !== e.inserts_owner0 ||
              out_data.inserts_owner1 !== e.inserts_owner1 ||
              out_data.inserts_total !== e.inserts_total) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: exp %p got %p", e, out_data);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    logic [19:0] p1, p2, p3, pg;
    int b0, bm, r, g, counted;
    for (int i = 0; i < NBKT*NWAY; i++) begin
      pt_valid[i] = 1'b0;
      pt_dirty[i] = 1'b0;
      pt_owner[i] = 1'b0;
      pt_page[i]  = '0;
    end

    // directed
    b0 = bucket_of(20'd0);
    bm = bucket_of(20'hFFFFF);
    p1 = next_in_bucket(20'd0, b0);
    p2 = next_in_bucket(p1, b0);
    p3 = next_in_bucket(p2, b0);
    add_word(hpt_pkg::KIND_ACCESS, 20'd0, 1'b0, 1'b0, 6'd0);
    add_word(hpt_pkg::KIND_ACCESS, 20'd0, 1'b0, 1'b0, 6'h3F);
    add_word(hpt_pkg::KIND_ACCESS, 20'd0, 1'b1, 1'b1, 6'd0);
    add_word(hpt_pkg::KIND_ACCESS, 20'd0, 1'b0, 1'b1, 6'd0);
    add_word(hpt_pkg::KIND_ACCESS, p1, 1'b1, 1'b0, 6'd0);
    add_word(hpt_pkg::KIND_ACCESS, p2, 1'b0, 1'b1, 6'd0);
    add_word(hpt_pkg::KIND_ACCESS, p3, 1'b1, 1'b0, 6'd0);
    add_word(hpt_pkg::KIND_ACCESS, p3, 1'b1, 1'b1, 6'd0);
    add_word(hpt_pkg::KIND_ACCESS, 20'd0, 1'b1, 1'b0, 6'd0);
    add_word(hpt_pkg::KIND_FLUSH, 20'hFFFFF, 1'b1, 1'b1, 6'(b0));
    add_word(hpt_pkg::KIND_ACCESS, p3, 1'b1, 1'b1, 6'd0);
    add_word(hpt_pkg::KIND_CLEAR, 20'd0, 1'b0, 1'b0, 6'(b0));
    add_word(hpt_pkg::KIND_FLUSH, 20'd0, 1'b0, 1'b0, 6'(b0));
    add_word(hpt_pkg::KIND_CLEAR, 20'd0, 1'b1, 1'b1, 6'(b0));
    add_word(hpt_pkg::KIND_ACCESS, 20'hFFFFF, 1'b1, 1'b1, 6'h3F);
    add_word(hpt_pkg::KIND_ACCESS, 20'hFFFFF, 1'b1, 1'b0, 6'h3F);
    add_word(hpt_pkg::KIND_ACCESS, 20'hFFFFF, 1'b0, 1'b0, 6'h3F);
    add_word(KIND_NOP, 20'd0, 1'b0, 1'b0, 6'd0);
    add_word(KIND_NOP, 20'hFFFFF, 1'b1, 1'b1, 6'h3F);
    add_word(hpt_pkg::KIND_FLUSH, 20'd0, 1'b1, 1'b0, 6'(bm));
    add_word(hpt_pkg::KIND_CLEAR, 20'hFFFFF, 1'b0, 1'b1, 6'(bm));
    add_word(hpt_pkg::KIND_FLUSH, 20'h55555, 1'b1, 1'b1, 6'h3F);
    add_word(hpt_pkg::KIND_CLEAR, 20'hAAAAA, 1'b0, 1'b0, 6'd0);

    // hot pages crowded into a few buckets so that hits and full buckets occur
    for (int i = 0; i < GROUPS; i++) begin
      pg = 20'($urandom_range(20'hFFFFF));
      hot_bkt[i] = 6'(bucket_of(pg));
      hot_pages[i*PER_GRP] = pg;
      for (int j = 1; j < PER_GRP; j++) begin
        pg = next_in_bucket(pg, hot_bkt[i]);
        hot_pages[i*PER_GRP + j] = pg;
      end
    end

    counted = 0;
    while (counted < N_RAND) begin
      r = $urandom_range(99);
      g = $urandom_range(GROUPS - 1);
      if (r < 70) begin
        add_word(hpt_pkg::KIND_ACCESS, hot_pages[$urandom_range(GROUPS*PER_GRP - 1)],
                 1'($urandom_range(1)), 1'($urandom_range(1)), 6'($urandom_range(63)));
      end else if (r < 80) begin
        add_word(hpt_pkg::KIND_ACCESS, 20'($urandom_range(20'hFFFFF)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), 6'($urandom_range(63)));
      end else if (r < 96) begin
        add_word((r < 88) ? hpt_pkg::KIND_FLUSH : hpt_pkg::KIND_CLEAR,
                 20'($urandom_range(20'hFFFFF)),
                 1'($urandom_range(1)), 1'($urandom_range(1)),
                 $urandom_range(1) ? hot_bkt[g] : 6'($urandom_range(63)));
      end else begin
        add_word(KIND_NOP, 20'($urandom_range(20'hFFFFF)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 6'($urandom_range(63)));
        counted--;
      end
      counted++;
    end
    n_items = stim_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (resp_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hpt_pkg.sv
rtl/core/hpt_ram.sv
rtl/core/hpt_hash.sv
rtl/core/hpt_dp.sv
rtl/core/hpt_ctrl.sv
rtl/core/hashed_page_table_unit.sv
test/tb_top.sv
